[hdl/matinv_pkg.sv]
// Package for the 3x3 adjugate matrix inverse: widths, constants and the
// per-lane divider input bundle. No dependencies.
`timescale 1ns / 1ps
package matinv_pkg;
   localparam int DataW     = 16;          // Q4.12 input entry
   localparam int ResW      = 32;          // Q16.16 result entry
   localparam int CofW      = 32;          // cofactor magnitude
   localparam int MinorW    = 33;          // signed 2x2 minor
   localparam int DetW      = 48;          // determinant magnitude
   localparam int DetProdW  = DataW + MinorW;
   localparam int DetSumW   = DetProdW + 2;
   localparam int NumShift  = 28;          // Q.24 / Q.36 -> Q.16
   localparam int LoW       = ResW - NumShift;
   localparam int HiW       = CofW - LoW;
   localparam int DivSteps  = ResW;
   localparam int LaneStages = DivSteps + 1;
   localparam int TopStages = 4;
   localparam int NumEnt    = 9;
   localparam int InDataW   = NumEnt * DataW;
   localparam int OutDataW  = NumEnt * ResW;

   localparam logic [DetW-1:0] ThreshReset = 48'd687194767;
   localparam logic [ResW-1:0] PosMax = 32'h7FFF_FFFF;
   localparam logic [ResW-1:0] NegMax = 32'h8000_0000;

   typedef struct packed {
      logic [CofW-1:0] cmag;
      logic            neg;
      logic [DetW-1:0] dmag;
   } lane_in_type;
endpackage

[hdl/matrix_3x3_cofactor_inverse.sv]
// Top level: 3x3 inverse by adjugate. Minors and determinant front end,
// nine matinv_lane dividers, merge into the result beat. Uses matinv_pkg.
// One beat per cycle whenever the pipeline is not stalled.
// Pipeline: 4 front-end stages, 33 divider stages, 1 output register.
// Whole pipeline stalls only while a result beat waits on rsp_tready.
// Synchronous reset clears valid flags and restores the threshold register.
`timescale 1ns / 1ps
module matrix_3x3_cofactor_inverse (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // m00,m01,m02,m10,m11,m12,m20,m21,m22 from bit 0 up, 16 bits each
   input  logic [matinv_pkg::InDataW-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // r00,r01,r02,r10,r11,r12,r20,r21,r22 from bit 0 up, 32 bits each
   output logic [matinv_pkg::OutDataW-1:0]   rsp_tdata,
   // singular
   output logic                              rsp_tuser,
   input  logic                              csr_wr_en,
   input  logic [matinv_pkg::DetW-1:0]       csr_wr_data
);
   localparam int VldN = matinv_pkg::TopStages + matinv_pkg::LaneStages;

   logic en;
   logic [matinv_pkg::DetW-1:0] thr_ff;
   logic vld_ff [0:VldN-1];
   logic sng_ff [0:matinv_pkg::LaneStages-1];

   logic signed [matinv_pkg::DataW-1:0]    a [0:2][0:2];
   logic signed [2*matinv_pkg::DataW-1:0]  p1_ff [0:8];
   logic signed [2*matinv_pkg::DataW-1:0]  p2_ff [0:8];
   logic signed [matinv_pkg::DataW-1:0]    a0_ff1 [0:2];
   logic signed [matinv_pkg::DataW-1:0]    a0_ff2 [0:2];
   logic signed [matinv_pkg::MinorW-1:0]   mnr_ff [0:8];
   logic signed [matinv_pkg::DetProdW-1:0] dt_ff [0:2];
   logic [matinv_pkg::CofW-1:0]            cmag3_ff [0:8];
   logic                                   cneg3_ff [0:8];
   logic [matinv_pkg::CofW-1:0]            cmag4_ff [0:8];
   logic                                   cneg4_ff [0:8];
   logic signed [matinv_pkg::DetSumW-1:0]  det;
   logic [matinv_pkg::DetSumW-1:0]         det_abs;
   logic [matinv_pkg::DetW-1:0]            dmag_ff;
   logic                                   dneg_ff;
   logic                                   sng_in;
   logic [matinv_pkg::ResW-1:0]            res [0:8];
   logic                                   rsp_tvalid_ff;
   logic [matinv_pkg::OutDataW-1:0]        rsp_tdata_ff;
   logic                                   rsp_tuser_ff;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= matinv_pkg::ThreshReset;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int R1 = (i == 0) ? 1 : 0;
         localparam int R2 = (i == 2) ? 1 : 2;
         localparam int C1 = (j == 0) ? 1 : 0;
         localparam int C2 = (j == 2) ? 1 : 2;
         localparam int K  = i * 3 + j;
         // output entry (i,j) takes minor (j,i)
         localparam int KT = j * 3 + i;
         localparam bit Flip = ((i + j) % 2) == 1;
         logic signed [matinv_pkg::MinorW-1:0] cof;
         matinv_pkg::lane_in_type              lane_in;

         assign a[i][j] = req_tdata[K*matinv_pkg::DataW +: matinv_pkg::DataW];
         assign cof = Flip ? -mnr_ff[KT] : mnr_ff[KT];
         assign lane_in = '{cmag: cmag4_ff[K], neg: cneg4_ff[K] ^ dneg_ff, dmag: dmag_ff};

         always_ff @(posedge clock) begin
            if (en) begin
               p1_ff[K]  <= a[R1][C1] * a[R2][C2];
               p2_ff[K]  <= a[R1][C2] * a[R2][C1];
               mnr_ff[K] <= matinv_pkg::MinorW'(p1_ff[K]) - matinv_pkg::MinorW'(p2_ff[K]);
               cneg3_ff[K] <= cof[matinv_pkg::MinorW-1];
               cmag3_ff[K] <= cof[matinv_pkg::MinorW-1] ? matinv_pkg::CofW'(-cof)
                                                         : matinv_pkg::CofW'(cof);
               cneg4_ff[K] <= cneg3_ff[K];
               cmag4_ff[K] <= cmag3_ff[K];
            end
         end

         matinv_lane u_lane (
            .clock   (clock),
            .en      (en),
            .lane_in (lane_in),
            .res     (res[K])
         );
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_det
      always_ff @(posedge clock) begin
         if (en) begin
            a0_ff1[j] <= a[0][j];
            a0_ff2[j] <= a0_ff1[j];
            dt_ff[j]  <= a0_ff2[j] * mnr_ff[j];
         end
      end
   end

   assign det = matinv_pkg::DetSumW'(dt_ff[0]) - matinv_pkg::DetSumW'(dt_ff[1])
              + matinv_pkg::DetSumW'(dt_ff[2]);
   assign det_abs = det[matinv_pkg::DetSumW-1] ? -det : det;
   assign sng_in  = (dmag_ff == '0) || (dmag_ff < thr_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         dmag_ff <= det_abs[matinv_pkg::DetW-1:0];
         dneg_ff <= det[matinv_pkg::DetSumW-1];
         sng_ff[0] <= sng_in;
         for (int s = 1; s < matinv_pkg::LaneStages; s++) begin
            sng_ff[s] <= sng_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < VldN; s++) begin
            vld_ff[s] <= 1'b0;
         end
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int s = 1; s < VldN; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         rsp_tvalid_ff <= vld_ff[VldN-1];
      end
   end

   // merge: zero all entries on a singular matrix
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tuser_ff <= sng_ff[matinv_pkg::LaneStages-1];
         for (int e = 0; e < matinv_pkg::NumEnt; e++) begin
            rsp_tdata_ff[e*matinv_pkg::ResW +: matinv_pkg::ResW] <=
               sng_ff[matinv_pkg::LaneStages-1] ? '0 : res[e];
         end
      end
   end
endmodule

[hdl/matinv_lane.sv]
// One divider lane: restoring divide of |cofactor|<<28 by |det|, one quotient
// bit per stage, then sign and Q16.16 saturation. Depends on matinv_pkg.
`timescale 1ns / 1ps
module matinv_lane (
   input  logic                          clock,
   input  logic                          en,
   input  matinv_pkg::lane_in_type       lane_in,
   output logic [matinv_pkg::ResW-1:0]   res
);
   logic [matinv_pkg::DetW-1:0] rem_ff [0:matinv_pkg::DivSteps];
   logic [matinv_pkg::DetW-1:0] d_ff   [0:matinv_pkg::DivSteps];
   logic [matinv_pkg::ResW-1:0] lo_ff  [0:matinv_pkg::DivSteps];
   logic [matinv_pkg::ResW-1:0] q_ff   [0:matinv_pkg::DivSteps];
   logic                        neg_ff [0:matinv_pkg::DivSteps];
   logic                        ovf_ff [0:matinv_pkg::DivSteps];

   logic [matinv_pkg::DetW-1:0] rem_in [1:matinv_pkg::DivSteps];
   logic [matinv_pkg::ResW-1:0] q_in   [1:matinv_pkg::DivSteps];
   logic [matinv_pkg::DetW-1:0] hi_in;
   logic [matinv_pkg::ResW-1:0] qf;

   assign hi_in = matinv_pkg::DetW'(lane_in.cmag[matinv_pkg::CofW-1:matinv_pkg::LoW]);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= hi_in;
         d_ff[0]   <= lane_in.dmag;
         lo_ff[0]  <= {lane_in.cmag[matinv_pkg::LoW-1:0], {matinv_pkg::NumShift{1'b0}}};
         q_ff[0]   <= '0;
         neg_ff[0] <= lane_in.neg;
         ovf_ff[0] <= (hi_in >= lane_in.dmag);
      end
   end

   for (genvar k = 0; k < matinv_pkg::DivSteps; k++) begin : g_step
      logic [matinv_pkg::DetW:0] t;
      logic [matinv_pkg::DetW:0] diff;
      logic                      ge;
      assign t    = {rem_ff[k], lo_ff[k][matinv_pkg::ResW-1]};
      assign diff = t - {1'b0, d_ff[k]};
      assign ge   = (t >= {1'b0, d_ff[k]});
      assign rem_in[k+1] = ge ? diff[matinv_pkg::DetW-1:0] : t[matinv_pkg::DetW-1:0];
      assign q_in[k+1]   = {q_ff[k][matinv_pkg::ResW-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in[k+1];
            q_ff[k+1]   <= q_in[k+1];
            lo_ff[k+1]  <= {lo_ff[k][matinv_pkg::ResW-2:0], 1'b0};
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   assign qf = q_ff[matinv_pkg::DivSteps];

   always_comb begin
      if (neg_ff[matinv_pkg::DivSteps]) begin
         if (ovf_ff[matinv_pkg::DivSteps] || qf > matinv_pkg::NegMax) begin
            res = matinv_pkg::NegMax;
         end else begin
            res = ~qf + 1'b1;
         end
      end else begin
         if (ovf_ff[matinv_pkg::DivSteps] || qf[matinv_pkg::ResW-1]) begin
            res = matinv_pkg::PosMax;
         end else begin
            res = qf;
         end
      end
   end
endmodule
